// ----- hdl/vde_pkg.sv -----
package vde_pkg;

  // field widths fixed by the interface
  localparam int ELEM_W = 8;
  localparam int DIST_W = 26;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_METRIC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED = 1'd1;

  // sequencer step counts
  localparam int MAC_STEPS  = 5;   // d*d, a*a, b*b, a*b, final add
  localparam int PROD_STEPS = 3;   // magA*magB, dot*dot, load divider
  localparam int DIV_STEPS  = 33;  // quotient bits of dot^2 * 2^32 / (magA*magB)
  localparam int SQRT_STEPS = 17;  // root bits of the 34-bit radicand
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // cosine fixed point: one is 65536 in Q2.16
  localparam int WORK_W = 2 * SQRT_STEPS;
  localparam int RT_W   = SQRT_STEPS;
  localparam int SR_W   = RT_W + 2;
  localparam int Q_W    = 18;
  localparam logic [Q_W-1:0] Q_ONE = 18'd65536;

  typedef struct packed {
    logic [ELEM_W-1:0] elem_a;
    logic [ELEM_W-1:0] elem_b;
    logic              last;
  } vde_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              zero_vector;
    logic              too_long;
  } vde_out_t;

endpackage

// ----- hdl/vector_distance_engine_8bit_core.sv -----
// Each element pair is accepted in idle, then runs 5 multiply-accumulate steps on
//   the shared multiplier; a pair past the length bound runs only the final step.
// Last pair: the L2 result goes through the done state to the output register;
//   cosine adds 3 product steps on the shared multiplier, 33 divide steps and 17
//   square-root steps on the shared subtractor.
// A new pair is accepted only in idle; the output register holds a result while the
//   next vector streams in. Reset is synchronous: accumulators, count and handshake clear.
module vector_distance_engine_8bit_core #(
  parameter int MAX_LEN = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vde_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic                                cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  vde_pkg::vde_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output vde_pkg::vde_out_t                   out_data
);
  import vde_pkg::*;

  localparam int SUM_W = $clog2(MAX_LEN * 65025 + 1);
  localparam int DOT_W = SUM_W + 1;
  localparam int OP_W  = DOT_W;
  localparam int PW    = 2 * SUM_W;
  localparam int SUB_W = PW + 1;
  localparam int CNT_W = $clog2(MAX_LEN + 2);
  localparam int EXT_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_LEN + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MAC  = 6'b000010,
    S_PROD = 6'b000100,
    S_DIV  = 6'b001000,
    S_SQRT = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic                     metric_r, metric_nxt;
  logic                     signed_r, signed_nxt;
  logic [SUM_W-1:0]         sq_diff_r, sq_diff_nxt;
  logic [SUM_W-1:0]         mag_a_r, mag_a_nxt;
  logic [SUM_W-1:0]         mag_b_r, mag_b_nxt;
  logic [DOT_W-1:0]         dot_r, dot_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  vde_out_t                 out_data_r, out_data_nxt;

  logic signed [8:0]        a_r, a_nxt;
  logic signed [8:0]        b_r, b_nxt;
  logic                     last_r, last_nxt;
  logic                     zero_vec_r, zero_vec_nxt;
  logic                     cos_r, cos_nxt;
  logic signed [2*OP_W-1:0] prod_r, prod_nxt;
  logic [PW-1:0]            div_d_r, div_d_nxt;
  logic [PW-1:0]            rem_r, rem_nxt;
  logic                     sq0_r, sq0_nxt;
  logic [WORK_W-1:0]        work_r, work_nxt;
  logic [RT_W-1:0]          root_r, root_nxt;
  logic [SR_W-1:0]          srem_r, srem_nxt;

  // shared multiplier and subtractor
  logic signed [OP_W-1:0]   mul_x, mul_y;
  logic signed [2*OP_W-1:0] mul_p;
  logic [SUB_W-1:0]         sub_x, sub_y;
  logic [SUB_W:0]           sub_diff;
  logic                     sub_ge;

  logic signed [9:0]        d_v;
  logic                     in_bit;
  logic                     accept;
  logic                     mags_zero;
  logic [Q_W-1:0]           q_ext, cos_dist;
  logic [EXT_W-1:0]         l2_ext;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign d_v      = {a_r[8], a_r} - {b_r[8], b_r};
  assign mul_p    = mul_x * mul_y;
  assign sub_diff = {1'b0, sub_x} - {1'b0, sub_y};
  assign sub_ge   = !sub_diff[SUB_W];
  assign in_bit   = (step_r == '0) ? sq0_r : 1'b0;

  assign mags_zero = (mag_a_r == '0) || (mag_b_r == '0);
  assign q_ext     = {1'b0, root_r};
  assign cos_dist  = dot_r[DOT_W-1] ? (Q_ONE + q_ext) : (Q_ONE - q_ext);
  assign l2_ext    = EXT_W'(sq_diff_r);

  // select operands of the shared units
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    sub_x = '0;
    sub_y = '0;
    case (state_r)
      S_MAC: begin
        case (step_r)
          STEP_W'(0): begin
            mul_x = {{(OP_W-10){d_v[9]}}, d_v};
            mul_y = {{(OP_W-10){d_v[9]}}, d_v};
          end
          STEP_W'(1): begin
            mul_x = {{(OP_W-9){a_r[8]}}, a_r};
            mul_y = {{(OP_W-9){a_r[8]}}, a_r};
          end
          STEP_W'(2): begin
            mul_x = {{(OP_W-9){b_r[8]}}, b_r};
            mul_y = {{(OP_W-9){b_r[8]}}, b_r};
          end
          STEP_W'(3): begin
            mul_x = {{(OP_W-9){a_r[8]}}, a_r};
            mul_y = {{(OP_W-9){b_r[8]}}, b_r};
          end
          default: begin
            mul_x = '0;
            mul_y = '0;
          end
        endcase
      end
      S_PROD: begin
        if (step_r == STEP_W'(0)) begin
          mul_x = $signed({1'b0, mag_a_r});
          mul_y = $signed({1'b0, mag_b_r});
        end else begin
          mul_x = $signed(dot_r);
          mul_y = $signed(dot_r);
        end
      end
      S_DIV: begin
        sub_x = {rem_r, in_bit};
        sub_y = {1'b0, div_d_r};
      end
      S_SQRT: begin
        sub_x = SUB_W'({srem_r, work_r[WORK_W-1:WORK_W-2]});
        sub_y = SUB_W'({root_r, 2'b01});
      end
      default: begin
        sub_x = '0;
        sub_y = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    metric_nxt    = metric_r;
    signed_nxt    = signed_r;
    sq_diff_nxt   = sq_diff_r;
    mag_a_nxt     = mag_a_r;
    mag_b_nxt     = mag_b_r;
    dot_nxt       = dot_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    last_nxt      = last_r;
    zero_vec_nxt  = zero_vec_r;
    cos_nxt       = cos_r;
    prod_nxt      = mul_p;
    div_d_nxt     = div_d_r;
    rem_nxt       = rem_r;
    sq0_nxt       = sq0_r;
    work_nxt      = work_r;
    root_nxt      = root_r;
    srem_nxt      = srem_r;

    // take configuration writes
    if (cfg_we) begin
      if (cfg_index == CFG_METRIC) begin
        metric_nxt = cfg_wdata;
      end
      if (cfg_index == CFG_SIGNED) begin
        signed_nxt = cfg_wdata;
      end
    end

    case (state_r)
      S_IDLE: begin
        // latch the item and count it, or skip it past the length bound
        if (accept) begin
          a_nxt    = signed_r ? $signed({in_data.elem_a[7], in_data.elem_a})
                              : $signed({1'b0, in_data.elem_a});
          b_nxt    = signed_r ? $signed({in_data.elem_b[7], in_data.elem_b})
                              : $signed({1'b0, in_data.elem_b});
          last_nxt = in_data.last;
          state_nxt = S_MAC;
          if (count_r < CNT_MAX) begin
            count_nxt = count_r + CNT_W'(1);
            step_nxt  = '0;
          end else begin
            count_nxt = CNT_SAT;
            step_nxt  = STEP_W'(MAC_STEPS - 1);
          end
        end
      end
      S_MAC: begin
        // add the product of the previous step
        case (step_r)
          STEP_W'(1): sq_diff_nxt = sq_diff_r + prod_r[SUM_W-1:0];
          STEP_W'(2): mag_a_nxt   = mag_a_r + prod_r[SUM_W-1:0];
          STEP_W'(3): mag_b_nxt   = mag_b_r + prod_r[SUM_W-1:0];
          STEP_W'(4): dot_nxt     = dot_r + prod_r[DOT_W-1:0];
          default: ;
        endcase
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(MAC_STEPS - 1)) begin
          step_nxt     = '0;
          zero_vec_nxt = metric_r && mags_zero;
          cos_nxt      = metric_r && !mags_zero;
          if (!last_r) begin
            state_nxt = S_IDLE;
          end else if (metric_r && !mags_zero) begin
            state_nxt = S_PROD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_PROD: begin
        // form divisor and dividend, then seed the divider
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          div_d_nxt = prod_r[PW-1:0];
        end
        if (step_r == STEP_W'(PROD_STEPS - 1)) begin
          rem_nxt   = {1'b0, prod_r[PW-1:1]};
          sq0_nxt   = prod_r[0];
          work_nxt  = '0;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // one restoring division step per cycle
        rem_nxt  = sub_ge ? sub_diff[PW-1:0] : sub_x[PW-1:0];
        work_nxt = {work_r[WORK_W-2:0], sub_ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          step_nxt  = '0;
          root_nxt  = '0;
          srem_nxt  = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        // one root bit per cycle
        srem_nxt = sub_ge ? sub_diff[SR_W-1:0] : sub_x[SR_W-1:0];
        root_nxt = {root_r[RT_W-2:0], sub_ge};
        work_nxt = {work_r[WORK_W-3:0], 2'b00};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SQRT_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hand over the result once the output register is free, then clear
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.zero_vector = zero_vec_r;
          out_data_nxt.too_long    = (count_r > CNT_MAX);
          if (cos_r) begin
            out_data_nxt.distance = DIST_W'(cos_dist);
          end else if (zero_vec_r) begin
            out_data_nxt.distance = '0;
          end else begin
            out_data_nxt.distance = l2_ext[DIST_W-1:0];
          end
          sq_diff_nxt = '0;
          mag_a_nxt   = '0;
          mag_b_nxt   = '0;
          dot_nxt     = '0;
          count_nxt   = '0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and accumulator registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      metric_r    <= 1'b0;
      signed_r    <= 1'b1;
      sq_diff_r   <= '0;
      mag_a_r     <= '0;
      mag_b_r     <= '0;
      dot_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      metric_r    <= metric_nxt;
      signed_r    <= signed_nxt;
      sq_diff_r   <= sq_diff_nxt;
      mag_a_r     <= mag_a_nxt;
      mag_b_r     <= mag_b_nxt;
      dot_r       <= dot_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    last_r     <= last_nxt;
    zero_vec_r <= zero_vec_nxt;
    cos_r      <= cos_nxt;
    prod_r     <= prod_nxt;
    div_d_r    <= div_d_nxt;
    rem_r      <= rem_nxt;
    sq0_r      <= sq0_nxt;
    work_r     <= work_nxt;
    root_r     <= root_nxt;
    srem_r     <= srem_nxt;
  end

endmodule
